// ----- design/u2u8_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the UTF-16BE to UTF-8 transcoder.
// Used by the front end, the job queue and the back end; depends on nothing.
package u2u8_pkg;

	localparam logic [7:0] BOM_FIRST  = 8'hFE;
	localparam logic [7:0] BOM_SECOND = 8'hFF;

	localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
	localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

	localparam logic [20:0] SUPP_BASE = 21'h10000;

	localparam logic [20:0] LIMIT_ONE   = 21'h80;
	localparam logic [20:0] LIMIT_TWO   = 21'h800;
	localparam logic [20:0] LIMIT_THREE = 21'h10000;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_HELD  = 2'd1,
		PH_BODY  = 2'd2
	} phase_t;

	// One symbol is either a raw byte in value[7:0] or a code point.
	typedef struct packed {
		logic        is_code;
		logic [20:0] value;
	} sym_t;

	typedef struct packed {
		sym_t       sym0;
		sym_t       sym1;
		logic [1:0] count;
		logic       last;
	} job_t;

	function automatic job_t add_sym(job_t j, sym_t s);
		job_t r;
		r = j;
		if (j.count == 2'd0) begin
			r.sym0 = s;
		end else begin
			r.sym1 = s;
		end
		r.count = j.count + 2'd1;
		return r;
	endfunction

endpackage

// ----- design/utf16be_to_utf8_transcoder.sv -----
`timescale 1ns / 1ps
// Top level of the UTF-16BE to UTF-8 transcoder: front end, job queue, back end.
// Depends on u2u8_pkg, u2u8_front, u2u8_fifo and u2u8_back.

// The block takes one byte of a text string per transfer and gives its output
// bytes one per cycle when not stalled. A string opening with FE FF is read as
// big-endian UTF-16 and transcoded to UTF-8; any other string passes through
// byte for byte. An input byte is taken in every cycle while the job queue
// (QUEUE_DEPTH entries) has room, so input and output stall independently. The
// pace is set by the back end's single output register at one byte per cycle:
// a UTF-16 unit of two input bytes gives one to three output bytes (four for a
// surrogate pair, up to six when an unpaired high surrogate is flushed), and
// pass-through gives one output byte per input byte. The final transfer of a
// string always ends in a result with tlast set; if no byte is left it carries
// tdata zero and byte_valid zero.
module utf16be_to_utf8_transcoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic [1:0] m_axis_tuser,  // [0] byte_valid, [1] run_last
	output logic       m_axis_tlast
);
	import u2u8_pkg::*;

	logic q_full, q_push, q_pop, q_empty;
	job_t push_job, head_job;

	u2u8_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (push_job)
	);

	u2u8_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head_job (head_job)
	);

	u2u8_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_job      (head_job),
		.q_pop      (q_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_byte   (m_axis_tdata),
		.byte_valid (m_axis_tuser[0]),
		.run_last   (m_axis_tuser[1]),
		.text_end   (m_axis_tlast)
	);

endmodule

// ----- design/u2u8_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts input bytes, tracks the byte-order mark and surrogate pairs,
// and turns transfers into jobs of up to two symbols. Depends on u2u8_pkg.
module u2u8_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_byte,
	input  logic               in_last,
	input  logic               q_full,
	output logic               q_push,
	output u2u8_pkg::job_t     q_job
);
	import u2u8_pkg::*;

	phase_t      phase_q, phase_next;
	logic        mode_q, mode_next;
	logic [7:0]  held_q, held_next;
	logic        held_valid_q, held_valid_next;
	logic [15:0] pend_q, pend_next;
	logic        pend_valid_q, pend_valid_next;
	logic        accept;
	job_t        job;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		phase_next = phase_q;
		unique case (phase_q)
			PH_START: begin
				if (in_byte == BOM_FIRST && !in_last) begin
					phase_next = PH_HELD;
				end else begin
					phase_next = PH_BODY;
				end
			end
			PH_HELD: phase_next = PH_BODY;
			default: phase_next = PH_BODY;
		endcase
		if (in_last) begin
			phase_next = PH_START;
		end
	end

	always_comb begin
		logic [15:0] unit;
		logic        is_high;
		logic        is_low;
		sym_t        s;
		unit            = {held_q, in_byte};
		is_high         = unit[15:10] == HIGH_SURR_TAG;
		is_low          = unit[15:10] == LOW_SURR_TAG;
		mode_next       = mode_q;
		held_next       = held_q;
		held_valid_next = held_valid_q;
		pend_next       = pend_q;
		pend_valid_next = pend_valid_q;
		job             = '0;
		job.last        = in_last;
		s               = '0;
		unique case (phase_q)
			PH_START: begin
				if (in_byte == BOM_FIRST && !in_last) begin
					held_next       = in_byte;
					held_valid_next = 1'b1;
				end else begin
					s         = '{is_code: 1'b0, value: {13'd0, in_byte}};
					job       = add_sym(job, s);
					mode_next = 1'b0;
				end
			end
			PH_HELD: begin
				held_valid_next = 1'b0;
				held_next       = '0;
				if (in_byte == BOM_SECOND) begin
					mode_next = 1'b1;
				end else begin
					mode_next = 1'b0;
					s         = '{is_code: 1'b0, value: {13'd0, BOM_FIRST}};
					job       = add_sym(job, s);
					s         = '{is_code: 1'b0, value: {13'd0, in_byte}};
					job       = add_sym(job, s);
				end
			end
			default: begin
				if (!mode_q) begin
					s   = '{is_code: 1'b0, value: {13'd0, in_byte}};
					job = add_sym(job, s);
				end else if (!held_valid_q) begin
					held_next       = in_byte;
					held_valid_next = 1'b1;
				end else begin
					held_valid_next = 1'b0;
					held_next       = '0;
					if (pend_valid_q && is_low) begin
						s = '{is_code: 1'b1,
							value: SUPP_BASE + {1'b0, pend_q[9:0], unit[9:0]}};
						job             = add_sym(job, s);
						pend_valid_next = 1'b0;
						pend_next       = '0;
					end else begin
						if (pend_valid_q) begin
							s   = '{is_code: 1'b1, value: {5'd0, pend_q}};
							job = add_sym(job, s);
						end
						if (is_high) begin
							pend_next       = unit;
							pend_valid_next = 1'b1;
						end else begin
							s               = '{is_code: 1'b1, value: {5'd0, unit}};
							job             = add_sym(job, s);
							pend_valid_next = 1'b0;
							pend_next       = '0;
						end
					end
				end
			end
		endcase
		if (in_last) begin
			if (pend_valid_next) begin
				s   = '{is_code: 1'b1, value: {5'd0, pend_next}};
				job = add_sym(job, s);
			end
			mode_next       = 1'b0;
			held_next       = '0;
			held_valid_next = 1'b0;
			pend_next       = '0;
			pend_valid_next = 1'b0;
		end
	end

	assign q_push = accept && (job.count != 2'd0 || in_last);
	assign q_job  = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_START;
			mode_q       <= 1'b0;
			held_q       <= '0;
			held_valid_q <= 1'b0;
			pend_q       <= '0;
			pend_valid_q <= 1'b0;
		end else if (accept) begin
			phase_q      <= phase_next;
			mode_q       <= mode_next;
			held_q       <= held_next;
			held_valid_q <= held_valid_next;
			pend_q       <= pend_next;
			pend_valid_q <= pend_valid_next;
		end
	end

endmodule

// ----- design/u2u8_fifo.sv -----
`timescale 1ns / 1ps
// Short job queue between the front end and the back end.
// Show-ahead read of the oldest job; depends on u2u8_pkg.
module u2u8_fifo #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  u2u8_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output u2u8_pkg::job_t head_job
);
	import u2u8_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	job_t          slots_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full     = count_q == FULL_CNT;
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_job = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ----- design/u2u8_back.sv -----
`timescale 1ns / 1ps
// Back end: walks the symbols of the oldest job and emits one UTF-8 or raw byte
// per cycle into the output register when not stalled. Depends on u2u8_pkg.
module u2u8_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  u2u8_pkg::job_t q_job,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic           byte_valid,
	output logic           run_last,
	output logic           text_end
);
	import u2u8_pkg::*;

	function automatic logic [1:0] sym_len_m1(sym_t s);
		if (!s.is_code || s.value < LIMIT_ONE) begin
			return 2'd0;
		end else if (s.value < LIMIT_TWO) begin
			return 2'd1;
		end else if (s.value < LIMIT_THREE) begin
			return 2'd2;
		end
		return 2'd3;
	endfunction

	function automatic logic [7:0] sym_byte(sym_t s, logic [1:0] len_m1, logic [1:0] k);
		logic [20:0] v;
		logic [1:0]  r;
		logic [5:0]  cont;
		v = s.value;
		r = len_m1 - k;
		unique case (r)
			2'd0:    cont = v[5:0];
			2'd1:    cont = v[11:6];
			2'd2:    cont = v[17:12];
			default: cont = v[20:18] == 3'd0 ? 6'd0 : {3'd0, v[20:18]};
		endcase
		if (len_m1 == 2'd0) begin
			return v[7:0];
		end else if (k != 2'd0) begin
			return {2'b10, cont};
		end
		unique case (len_m1)
			2'd1:    return {3'b110, v[10:6]};
			2'd2:    return {4'b1110, v[15:12]};
			default: return {5'b11110, v[20:18]};
		endcase
	endfunction

	logic       sym_idx_q;
	logic [1:0] byte_idx_q;
	logic       load;
	logic       emit;
	sym_t       cur;
	logic [1:0] cur_len_m1;
	logic       end_of_sym;
	logic       end_of_job;
	logic       bare_end;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       byte_valid_q, run_last_q, text_end_q;

	assign load       = !out_valid_q || out_ready;
	assign emit       = load && !q_empty;
	assign cur        = sym_idx_q ? q_job.sym1 : q_job.sym0;
	assign cur_len_m1 = sym_len_m1(cur);
	assign bare_end   = q_job.count == 2'd0;
	assign end_of_sym = byte_idx_q == cur_len_m1;
	assign end_of_job = bare_end ||
		(end_of_sym && ({1'b0, sym_idx_q} + 2'd1 == q_job.count));
	assign q_pop      = emit && end_of_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_idx_q   <= 1'b0;
			byte_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= emit;
			end
			if (emit) begin
				if (end_of_job) begin
					sym_idx_q  <= 1'b0;
					byte_idx_q <= '0;
				end else if (end_of_sym) begin
					sym_idx_q  <= 1'b1;
					byte_idx_q <= '0;
				end else begin
					byte_idx_q <= byte_idx_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q   <= bare_end ? 8'd0 : sym_byte(cur, cur_len_m1, byte_idx_q);
			byte_valid_q <= !bare_end;
			run_last_q   <= end_of_job;
			text_end_q   <= end_of_job && q_job.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign run_last   = run_last_q;
	assign text_end   = text_end_q;

endmodule

// ----- design/u2u8_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the transcoder's output stream, and the bind that
// attaches them to the top level. Depends on utf16be_to_utf8_transcoder.
module u2u8_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic [1:0] m_axis_tuser,
	input logic       m_axis_tlast
);

	// A stalled output transfer keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
		$stable(m_axis_tlast))
		else $error("output payload changed while stalled");

	// The end of a string is also the end of the run of its final input.
	a_end_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1])
		else $error("end of string without end of run");

	// A bare end marker only closes a string and carries a zero byte.
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |->
		m_axis_tlast && m_axis_tuser[1] && m_axis_tdata == 8'd0)
		else $error("malformed bare end marker");

endmodule

bind utf16be_to_utf8_transcoder u2u8_checker u_checker (.*);

// ----- verif/utf16be_to_utf8_transcoder_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for utf16be_to_utf8_transcoder: directed strings, then random strings.
// Depends on u2u8_pkg and the transcoder RTL; expected bytes come from a predictor kept here.
module utf16be_to_utf8_transcoder_tb;
	import u2u8_pkg::*;

	localparam int TEXT_ITEMS   = 393;
	localparam int CALM_ITEMS   = 60;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct packed {
		logic [7:0] data;
		logic       byte_valid;
		logic       run_last;
		logic       text_end;
	} utf8_out_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       typed;
		utf8_out_t  result;
	} text_row_t;

	localparam utf8_out_t NO_RESULT = '0;

	localparam text_row_t TEXT_ROWS [27] = '{
		'{8'hFE, 1'b1, 1'b1, '{8'hFE, 1'b1, 1'b1, 1'b1}},
		'{8'hFE, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
		'{8'hFE, 1'b0, 1'b0, NO_RESULT},
		'{8'h41, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b1}},
		'{8'hFE, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h07, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hD8, 1'b0, 1'b0, NO_RESULT},
		'{8'h3D, 1'b0, 1'b0, NO_RESULT},
		'{8'hDE, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'hDC, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'hDB, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hDB, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'h12, 1'b1, 1'b0, NO_RESULT}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic       s_axis_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic       m_axis_tlast;

	phase_t      text_phase = PH_START;
	logic        utf16_text = 1'b0;
	logic [7:0]  held_byte = 8'h00;
	logic        held_valid = 1'b0;
	logic [15:0] high_surr = 16'h0000;
	logic        high_valid = 1'b0;

	utf8_out_t unit_bytes[$];
	utf8_out_t expected_bytes[$];
	logic [7:0] text_bytes[$];

	bit gaps_on = 1'b1;
	int fail_count = 0;
	int cycle_count = 0;

	utf16be_to_utf8_transcoder u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void emit_byte(logic [7:0] b, logic valid);
		if (unit_bytes.size() < 6) begin
			unit_bytes.insert(unit_bytes.size(), '{b, valid, 1'b0, 1'b0});
		end
	endfunction

	function automatic void emit_code_point(logic [20:0] c);
		if (c < 21'h80) begin
			emit_byte(c[7:0], 1'b1);
		end else if (c < 21'h800) begin
			emit_byte({3'b110, c[10:6]}, 1'b1);
			emit_byte({2'b10, c[5:0]}, 1'b1);
		end else if (c < 21'h10000) begin
			emit_byte({4'b1110, c[15:12]}, 1'b1);
			emit_byte({2'b10, c[11:6]}, 1'b1);
			emit_byte({2'b10, c[5:0]}, 1'b1);
		end else begin
			emit_byte({5'b11110, c[20:18]}, 1'b1);
			emit_byte({2'b10, c[17:12]}, 1'b1);
			emit_byte({2'b10, c[11:6]}, 1'b1);
			emit_byte({2'b10, c[5:0]}, 1'b1);
		end
	endfunction

	function automatic void transcode_unit(logic [15:0] u);
		logic is_high;
		logic is_low;
		is_high = (u >= 16'hD800) && (u <= 16'hDBFF);
		is_low  = (u >= 16'hDC00) && (u <= 16'hDFFF);
		if (high_valid && is_low) begin
			emit_code_point(21'h10000 + {1'b0, high_surr[9:0], u[9:0]});
			high_valid = 1'b0;
			high_surr = 16'h0000;
		end else begin
			if (high_valid) begin
				emit_code_point({5'b0, high_surr});
				high_valid = 1'b0;
				high_surr = 16'h0000;
			end
			if (is_high) begin
				high_surr = u;
				high_valid = 1'b1;
			end else begin
				emit_code_point({5'b0, u});
			end
		end
	endfunction

	function automatic void transcode_byte(logic [7:0] b, logic last);
		unit_bytes.delete();
		case (text_phase)
			PH_START: begin
				if (b == 8'hFE && !last) begin
					held_byte = b;
					held_valid = 1'b1;
					text_phase = PH_HELD;
				end else begin
					emit_byte(b, 1'b1);
					utf16_text = 1'b0;
					text_phase = PH_BODY;
				end
			end
			PH_HELD: begin
				held_valid = 1'b0;
				held_byte = 8'h00;
				text_phase = PH_BODY;
				utf16_text = (b == 8'hFF);
				if (b != 8'hFF) begin
					emit_byte(8'hFE, 1'b1);
					emit_byte(b, 1'b1);
				end
			end
			default: begin
				if (!utf16_text) begin
					emit_byte(b, 1'b1);
				end else if (!held_valid) begin
					held_byte = b;
					held_valid = 1'b1;
				end else begin
					held_valid = 1'b0;
					transcode_unit({held_byte, b});
					held_byte = 8'h00;
				end
			end
		endcase
		if (last) begin
			if (high_valid) begin
				emit_code_point({5'b0, high_surr});
			end
			if (unit_bytes.size() == 0) begin
				emit_byte(8'h00, 1'b0);
			end
			unit_bytes[unit_bytes.size() - 1].text_end = 1'b1;
			text_phase = PH_START;
			utf16_text = 1'b0;
			held_byte = 8'h00;
			held_valid = 1'b0;
			high_surr = 16'h0000;
			high_valid = 1'b0;
		end
		if (unit_bytes.size() > 0) begin
			unit_bytes[unit_bytes.size() - 1].run_last = 1'b1;
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
			input utf8_out_t typed_result);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		transcode_byte(b, last);
		if (typed) begin
			expected_bytes.insert(expected_bytes.size(), typed_result);
		end else begin
			foreach (unit_bytes[i]) begin
				expected_bytes.insert(expected_bytes.size(), unit_bytes[i]);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
	endtask

	function automatic void add_text_byte(logic [7:0] b);
		text_bytes.insert(text_bytes.size(), b);
	endfunction

	function automatic void push_unit(logic [15:0] u);
		add_text_byte(u[15:8]);
		add_text_byte(u[7:0]);
	endfunction

	function automatic void build_text();
		int n;
		text_bytes.delete();
		case ($urandom_range(0, 9))
			6, 7: begin
				n = $urandom_range(1, 8);
				repeat (n) add_text_byte(8'($urandom));
			end
			8: begin
				add_text_byte(8'hFE);
				add_text_byte(8'($urandom_range(0, 254)));
				n = $urandom_range(0, 5);
				repeat (n) add_text_byte(8'($urandom));
			end
			9: begin
				add_text_byte($urandom_range(0, 1) ? 8'hFE : 8'($urandom));
			end
			default: begin
				add_text_byte(8'hFE);
				add_text_byte(8'hFF);
				n = $urandom_range(0, 6);
				repeat (n) begin
					case ($urandom_range(0, 7))
						0: push_unit(16'($urandom_range(16'h0000, 16'h007F)));
						1: push_unit(16'($urandom_range(16'h0080, 16'h07FF)));
						2: push_unit(16'($urandom_range(16'h0800, 16'hD7FF)));
						3: push_unit(16'($urandom_range(16'hE000, 16'hFFFF)));
						4: begin
							push_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
							push_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
						end
						5: push_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
						6: push_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
						default: push_unit(16'($urandom));
					endcase
				end
				if ($urandom_range(0, 3) == 0) begin
					add_text_byte(8'($urandom));
				end
			end
		endcase
	endfunction

	initial begin
		@(posedge clk);
		while (!arst_n) begin
			@(posedge clk);
		end
		forever begin
			if (gaps_on && $urandom_range(0, 2) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		utf8_out_t got;
		utf8_out_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1], m_axis_tlast};
			if (expected_bytes.size() == 0) begin
				$error("unexpected output transfer: out_byte %h", got.data);
				fail_count++;
			end else begin
				want = expected_bytes.pop_front();
				if (got.data !== want.data) begin
					$error("out_byte: expected %h, got %h", want.data, got.data);
					fail_count++;
				end
				if (got.byte_valid !== want.byte_valid) begin
					$error("byte_valid: expected %b, got %b", want.byte_valid, got.byte_valid);
					fail_count++;
				end
				if (got.run_last !== want.run_last) begin
					$error("run_last: expected %b, got %b", want.run_last, got.run_last);
					fail_count++;
				end
				if (got.text_end !== want.text_end) begin
					$error("text_end: expected %b, got %b", want.text_end, got.text_end);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int sent;
		sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (TEXT_ROWS[i]) begin
			send_byte(TEXT_ROWS[i].data, TEXT_ROWS[i].last, TEXT_ROWS[i].typed,
				TEXT_ROWS[i].result);
		end
		while (sent < TEXT_ITEMS) begin
			build_text();
			foreach (text_bytes[i]) begin
				send_byte(text_bytes[i], i == text_bytes.size() - 1, 1'b0, NO_RESULT);
				sent++;
			end
			if (sent > TEXT_ITEMS - CALM_ITEMS) begin
				gaps_on = 1'b0;
			end
		end
		s_axis_tvalid <= 1'b0;
		while (expected_bytes.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
design/u2u8_pkg.sv
design/u2u8_front.sv
design/u2u8_fifo.sv
design/u2u8_back.sv
design/utf16be_to_utf8_transcoder.sv
design/u2u8_checker.sv
verif/utf16be_to_utf8_transcoder_tb.sv
